// ===== hw/rtl/snat_pkg.sv =====
// Shared constants, types and checksum function for the source NAT rewriter.
package snat_pkg;

    localparam int TABLE_ENTRIES = 256;
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int LANES = 16;
    localparam int LANE_W = 4;
    localparam int GROUPS = (TABLE_ENTRIES + LANES - 1) / LANES;
    localparam int GRP_W = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int FULL_W = GRP_W + LANE_W;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_HEADER = 1'b1;

    localparam logic [15:0] IPV4_ETHERTYPE = 16'h0800;
    localparam logic [13:0] MIN_FRAME_BYTES = 14'd34;

    typedef struct packed {
        logic [GROUPS-1:0]             hit;
        logic [GROUPS-1:0][LANE_W-1:0] idx;
    } grp_match_t;

    function automatic logic [15:0] rewrite_checksum(
        input logic [15:0] hc,
        input logic [31:0] old_addr,
        input logic [31:0] new_addr
    );
        logic [18:0] s;
        logic [16:0] f1;
        logic [15:0] f2;
        s = {3'b000, ~hc} + {3'b000, ~old_addr[15:0]} + {3'b000, ~old_addr[31:16]}
            + {3'b000, new_addr[15:0]} + {3'b000, new_addr[31:16]};
        f1 = {1'b0, s[15:0]} + {14'b0, s[18:16]};
        f2 = f1[15:0] + {15'b0, f1[16]};
        return ~f2;
    endfunction

endpackage

// ===== hw/rtl/snat_cam.sv =====
// Match table keys and valid marks with per-group lowest-lane match search.
module snat_cam
    import snat_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_idx,
    input  logic [31:0]      wr_key,
    input  logic             wr_valid,
    input  logic [31:0]      lookup_key,
    output grp_match_t       grp_match
);

    logic [31:0]               key_reg [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0]  valid_reg;
    logic [GROUPS*LANES-1:0]   lane_hit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[wr_idx] <= wr_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_reg[wr_idx] <= wr_key;
        end
    end

    for (genvar n = 0; n < GROUPS * LANES; n++)
    begin : g_lane
        if (n < TABLE_ENTRIES)
        begin : g_real
            assign lane_hit[n] = valid_reg[n] && (key_reg[n] == lookup_key);
        end
        else
        begin : g_pad
            assign lane_hit[n] = 1'b0;
        end
    end

    always_comb
    begin
        grp_match = '0;
        for (int g = 0; g < GROUPS; g++)
        begin
            for (int l = LANES - 1; l >= 0; l--)
            begin
                if (lane_hit[g * LANES + l])
                begin
                    grp_match.hit[g] = 1'b1;
                    grp_match.idx[g] = LANE_W'(l);
                end
            end
        end
    end

endmodule

// ===== hw/rtl/snat_select.sv =====
// Lowest-slot selection across groups and replacement address memory.
module snat_select
    import snat_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_idx,
    input  logic [31:0]      wr_value,
    input  grp_match_t       grp_match,
    input  logic             eligible,
    output logic             hit_reg,
    output logic [31:0]      value_reg
);

    logic [31:0]      value_mem [TABLE_ENTRIES];
    logic [GRP_W-1:0] grp_sel;
    logic             any_hit;
    logic [FULL_W-1:0] full_idx;
    logic [IDX_W-1:0] rd_idx;

    always_comb
    begin
        grp_sel = '0;
        any_hit = 1'b0;
        for (int g = GROUPS - 1; g >= 0; g--)
        begin
            if (grp_match.hit[g])
            begin
                grp_sel = GRP_W'(g);
                any_hit = 1'b1;
            end
        end
    end

    assign full_idx = {grp_sel, grp_match.idx[grp_sel]};
    assign rd_idx = full_idx[IDX_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else if (advance)
        begin
            hit_reg <= any_hit && eligible;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            value_reg <= value_mem[rd_idx];
        end
        if (wr_en)
        begin
            value_mem[wr_idx] <= wr_value;
        end
    end

endmodule

// ===== hw/rtl/ipv4_source_address_rewriter.sv =====
// Top level of the IPv4 source NAT rewriter with incremental checksum update.
// A header result passes the s1, s2 and s3 registers and the output register before it is offered.
// Throughput: one item per cycle while no result waits on out_ready; write items leave no result.
// The pipeline holds as a whole while a result waits on out_ready.
// Reset clears all table valid marks and pipeline valids at once; no sweep.
module ipv4_source_address_rewriter
    import snat_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        action,
    input  logic [7:0]  entry_slot,
    input  logic [31:0] entry_key,
    input  logic [31:0] entry_value,
    input  logic        entry_valid,
    input  logic [13:0] frame_length,
    input  logic [15:0] ether_type,
    input  logic [31:0] source_address,
    input  logic [15:0] header_checksum,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        translated,
    output logic [31:0] source_address_out,
    output logic [15:0] header_checksum_out
);

    logic        advance;

    logic        s1_valid_reg;
    logic        s1_action_reg;
    logic [7:0]  s1_slot_reg;
    logic [31:0] s1_key_reg;
    logic [31:0] s1_value_reg;
    logic        s1_evalid_reg;
    logic [13:0] s1_flen_reg;
    logic [15:0] s1_etype_reg;
    logic [31:0] s1_saddr_reg;
    logic [15:0] s1_hc_reg;

    logic        s2_valid_reg;
    logic        s2_elig_reg;
    grp_match_t  s2_grp_reg;
    logic [31:0] s2_saddr_reg;
    logic [15:0] s2_hc_reg;

    logic        s3_valid_reg;
    logic [31:0] s3_saddr_reg;
    logic [15:0] s3_hc_reg;
    logic        s3_hit_reg;
    logic [31:0] s3_value_reg;

    logic        out_valid_reg;
    logic        translated_reg;
    logic [31:0] saddr_out_reg;
    logic [15:0] hc_out_reg;

    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    grp_match_t       grp_match;

    assign advance = !out_valid_reg || out_ready;
    assign in_ready = advance;

    assign wr_en = advance && s1_valid_reg && (s1_action_reg == ACT_WRITE)
                   && (32'(s1_slot_reg) < TABLE_ENTRIES);
    assign wr_idx = IDX_W'(s1_slot_reg);

    snat_cam u_cam (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (wr_en),
        .wr_idx     (wr_idx),
        .wr_key     (s1_key_reg),
        .wr_valid   (s1_evalid_reg),
        .lookup_key (s1_saddr_reg),
        .grp_match  (grp_match)
    );

    snat_select u_select (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .wr_en     (wr_en),
        .wr_idx    (wr_idx),
        .wr_value  (s1_value_reg),
        .grp_match (s2_grp_reg),
        .eligible  (s2_elig_reg),
        .hit_reg   (s3_hit_reg),
        .value_reg (s3_value_reg)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= in_valid;
            s2_valid_reg  <= s1_valid_reg && (s1_action_reg == ACT_HEADER);
            s3_valid_reg  <= s2_valid_reg;
            out_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            if (in_valid)
            begin
                s1_action_reg <= action;
                s1_slot_reg   <= entry_slot;
                s1_key_reg    <= entry_key;
                s1_value_reg  <= entry_value;
                s1_evalid_reg <= entry_valid;
                s1_flen_reg   <= frame_length;
                s1_etype_reg  <= ether_type;
                s1_saddr_reg  <= source_address;
                s1_hc_reg     <= header_checksum;
            end
            s2_elig_reg  <= (s1_flen_reg >= MIN_FRAME_BYTES)
                            && (s1_etype_reg == IPV4_ETHERTYPE);
            s2_grp_reg   <= grp_match;
            s2_saddr_reg <= s1_saddr_reg;
            s2_hc_reg    <= s1_hc_reg;
            s3_saddr_reg <= s2_saddr_reg;
            s3_hc_reg    <= s2_hc_reg;
            translated_reg <= s3_hit_reg;
            if (s3_hit_reg)
            begin
                saddr_out_reg <= s3_value_reg;
                hc_out_reg    <= rewrite_checksum(s3_hc_reg, s3_saddr_reg, s3_value_reg);
            end
            else
            begin
                saddr_out_reg <= s3_saddr_reg;
                hc_out_reg    <= s3_hc_reg;
            end
        end
    end

    assign out_valid           = out_valid_reg;
    assign translated          = translated_reg;
    assign source_address_out  = saddr_out_reg;
    assign header_checksum_out = hc_out_reg;

endmodule

// ===== tb/tb_top.sv =====
// Testbench for the IPv4 source NAT rewriter: table writes, lookups and checksum patching.
module tb_top;
    import snat_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int RANDOM_ITEMS = 1950;
    localparam int HOT_KEYS = 16;

    typedef struct packed {
        logic        action;
        logic [7:0]  entry_slot;
        logic [31:0] entry_key;
        logic [31:0] entry_value;
        logic        entry_valid;
        logic [13:0] frame_length;
        logic [15:0] ether_type;
        logic [31:0] source_address;
        logic [15:0] header_checksum;
    } nat_item_t;

    typedef struct packed {
        logic        translated;
        logic [31:0] source_address;
        logic [15:0] header_checksum;
    } nat_result_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        action;
    logic [7:0]  entry_slot;
    logic [31:0] entry_key;
    logic [31:0] entry_value;
    logic        entry_valid;
    logic [13:0] frame_length;
    logic [15:0] ether_type;
    logic [31:0] source_address;
    logic [15:0] header_checksum;
    logic        out_valid;
    logic        out_ready;
    logic        translated;
    logic [31:0] source_address_out;
    logic [15:0] header_checksum_out;

    logic        nat_valid [TABLE_ENTRIES];
    logic [31:0] nat_key   [TABLE_ENTRIES];
    logic [31:0] nat_value [TABLE_ENTRIES];
    logic [31:0] hot_keys  [HOT_KEYS];

    nat_result_t pending_results[$];
    nat_result_t want;

    int unsigned cycle_count;
    int unsigned error_count;
    int unsigned write_count;
    int unsigned header_count;
    int unsigned translate_count;
    int unsigned burst_left;
    int unsigned stall_mode;
    logic [6:0]  stall_phase;

    ipv4_source_address_rewriter u_top (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_valid            (in_valid),
        .in_ready            (in_ready),
        .action              (action),
        .entry_slot          (entry_slot),
        .entry_key           (entry_key),
        .entry_value         (entry_value),
        .entry_valid         (entry_valid),
        .frame_length        (frame_length),
        .ether_type          (ether_type),
        .source_address      (source_address),
        .header_checksum     (header_checksum),
        .out_valid           (out_valid),
        .out_ready           (out_ready),
        .translated          (translated),
        .source_address_out  (source_address_out),
        .header_checksum_out (header_checksum_out)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // RFC 1624 incremental update: HC' = ~(~HC + ~m + m') in ones-complement arithmetic
    function automatic logic [15:0] patch_checksum(
        input logic [15:0] hc,
        input logic [31:0] old_addr,
        input logic [31:0] new_addr
    );
        logic [15:0] inv_hc;
        logic [15:0] inv_lo;
        logic [15:0] inv_hi;
        logic [19:0] acc;
        inv_hc = ~hc;
        inv_lo = ~old_addr[15:0];
        inv_hi = ~old_addr[31:16];
        acc = 20'(inv_hc) + 20'(inv_lo) + 20'(inv_hi)
            + 20'(new_addr[15:0]) + 20'(new_addr[31:16]);
        while (acc[19:16] != 4'd0)
            acc = 20'(acc[15:0]) + 20'(acc[19:16]);
        return ~acc[15:0];
    endfunction

    function automatic nat_item_t make_write(
        input logic [7:0]  slot,
        input logic [31:0] key,
        input logic [31:0] value,
        input logic        valid
    );
        nat_item_t it;
        it.action          = ACT_WRITE;
        it.entry_slot      = slot;
        it.entry_key       = key;
        it.entry_value     = value;
        it.entry_valid     = valid;
        it.frame_length    = 14'($urandom);
        it.ether_type      = 16'($urandom);
        it.source_address  = $urandom;
        it.header_checksum = 16'($urandom);
        return it;
    endfunction

    function automatic nat_item_t make_header(
        input logic [13:0] flen,
        input logic [15:0] etype,
        input logic [31:0] saddr,
        input logic [15:0] hc
    );
        nat_item_t it;
        it.action          = ACT_HEADER;
        it.entry_slot      = 8'($urandom);
        it.entry_key       = $urandom;
        it.entry_value     = $urandom;
        it.entry_valid     = 1'($urandom);
        it.frame_length    = flen;
        it.ether_type      = etype;
        it.source_address  = saddr;
        it.header_checksum = hc;
        return it;
    endfunction

    task automatic translate_header(input nat_item_t it);
        nat_result_t res;
        res.translated      = 1'b0;
        res.source_address  = it.source_address;
        res.header_checksum = it.header_checksum;
        if (it.action == ACT_WRITE)
        begin
            write_count++;
            if (int'(it.entry_slot) < TABLE_ENTRIES)
            begin
                nat_key[it.entry_slot]   = it.entry_key;
                nat_value[it.entry_slot] = it.entry_value;
                nat_valid[it.entry_slot] = it.entry_valid;
            end
            return;
        end
        header_count++;
        if (it.frame_length >= MIN_FRAME_BYTES && it.ether_type == IPV4_ETHERTYPE)
        begin
            for (int i = 0; i < TABLE_ENTRIES; i++)
            begin
                if (nat_valid[i] && nat_key[i] == it.source_address)
                begin
                    res.translated      = 1'b1;
                    res.source_address  = nat_value[i];
                    res.header_checksum = patch_checksum(it.header_checksum,
                                                         it.source_address, nat_value[i]);
                    break;
                end
            end
        end
        if (res.translated)
            translate_count++;
        pending_results.push_back(res);
    endtask

    task automatic send_item(input nat_item_t it);
        in_valid        <= 1'b1;
        action          <= it.action;
        entry_slot      <= it.entry_slot;
        entry_key       <= it.entry_key;
        entry_value     <= it.entry_value;
        entry_valid     <= it.entry_valid;
        frame_length    <= it.frame_length;
        ether_type      <= it.ether_type;
        source_address  <= it.source_address;
        header_checksum <= it.header_checksum;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        translate_header(it);
    endtask

    task automatic push_item(input nat_item_t it);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        send_item(it);
    endtask

    task automatic test_passthrough();
        push_item(make_header(MIN_FRAME_BYTES, IPV4_ETHERTYPE, 32'h0000_0000, 16'h0000));
        push_item(make_header(14'h3FFF, IPV4_ETHERTYPE, 32'hFFFF_FFFF, 16'hFFFF));
        push_item(make_header(14'd0, 16'hFFFF, 32'hC0A8_0001, 16'h1234));
    endtask

    task automatic test_translation();
        push_item(make_write(8'd0, 32'h0A00_0001, 32'hC633_6401, 1'b1));
        push_item(make_write(8'd255, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1));
        push_item(make_write(8'd128, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1));
        push_item(make_header(MIN_FRAME_BYTES, IPV4_ETHERTYPE, 32'h0A00_0001, 16'hB1E6));
        push_item(make_header(14'h3FFF, IPV4_ETHERTYPE, 32'hFFFF_FFFF, 16'hFFFF));
        push_item(make_header(14'd60, IPV4_ETHERTYPE, 32'h0000_0000, 16'h0000));
        push_item(make_header(MIN_FRAME_BYTES - 14'd1, IPV4_ETHERTYPE, 32'h0A00_0001, 16'h4321));
        push_item(make_header(14'd100, 16'h86DD, 32'h0A00_0001, 16'h4321));
        push_item(make_header(14'd100, 16'h0801, 32'hFFFF_FFFF, 16'h0001));
        push_item(make_header(14'd100, 16'h0000, 32'h0000_0000, 16'hFFFE));
    endtask

    task automatic test_slot_removal();
        push_item(make_write(8'd0, 32'h0A00_0001, 32'h1111_2222, 1'b0));
        push_item(make_header(14'd64, IPV4_ETHERTYPE, 32'h0A00_0001, 16'h5A5A));
    endtask

    task automatic test_duplicate_keys();
        push_item(make_write(8'd10, 32'hAC10_0505, 32'h5555_AAAA, 1'b1));
        push_item(make_write(8'd3, 32'hAC10_0505, 32'hAAAA_5555, 1'b1));
        push_item(make_header(14'd1500, IPV4_ETHERTYPE, 32'hAC10_0505, 16'h8001));
        push_item(make_write(8'd3, 32'hAC10_0505, 32'hAAAA_5555, 1'b0));
        push_item(make_header(14'd1500, IPV4_ETHERTYPE, 32'hAC10_0505, 16'h7FFE));
    endtask

    task automatic test_random_traffic();
        nat_item_t it;
        int unsigned roll;
        logic [7:0]  slot;
        logic [31:0] key;
        logic [13:0] flen;
        logic [15:0] etype;
        for (int k = 0; k < HOT_KEYS; k++)
            hot_keys[k] = $urandom;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 25)
            begin
                slot = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 31)) : 8'($urandom);
                key  = ($urandom_range(0, 1) == 0) ? hot_keys[$urandom_range(0, HOT_KEYS - 1)]
                                                   : $urandom;
                it = make_write(slot, key, $urandom, $urandom_range(0, 9) < 8);
            end
            else
            begin
                roll = $urandom_range(0, 99);
                flen = (roll < 80) ? 14'($urandom_range(34, 1518))
                     : (roll < 90) ? 14'($urandom_range(0, 33)) : 14'($urandom);
                etype = ($urandom_range(0, 99) < 85) ? IPV4_ETHERTYPE : 16'($urandom);
                key = ($urandom_range(0, 99) < 65) ? hot_keys[$urandom_range(0, HOT_KEYS - 1)]
                                                   : $urandom;
                it = make_header(flen, etype, key, 16'($urandom));
            end
            push_item(it);
        end
    endtask

    always @(posedge clk)
    begin
        stall_phase <= stall_phase + 7'd1;
        if (stall_phase == 7'd0)
            stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= 1'($urandom);
            2: out_ready <= (stall_phase[3:0] < 4'd11);
            default: out_ready <= ($urandom_range(0, 5) == 0);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: translated=%0b source_address_out=%h",
                       translated, source_address_out);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (translated !== want.translated)
                begin
                    $error("translated: expected %0b, actual %0b",
                           want.translated, translated);
                    error_count++;
                end
                if (source_address_out !== want.source_address)
                begin
                    $error("source_address_out: expected %h, actual %h",
                           want.source_address, source_address_out);
                    error_count++;
                end
                if (header_checksum_out !== want.header_checksum)
                begin
                    $error("header_checksum_out: expected %h, actual %h",
                           want.header_checksum, header_checksum_out);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            nat_valid[i] = 1'b0;
            nat_key[i]   = 32'd0;
            nat_value[i] = 32'd0;
        end
        cycle_count     = 0;
        error_count     = 0;
        write_count     = 0;
        header_count    = 0;
        translate_count = 0;
        burst_left      = 0;
        stall_mode      = 0;
        stall_phase     = 7'd0;
        rst_n           <= 1'b0;
        in_valid        <= 1'b0;
        out_ready       <= 1'b0;
        action          <= ACT_HEADER;
        entry_slot      <= 8'd0;
        entry_key       <= 32'd0;
        entry_value     <= 32'd0;
        entry_valid     <= 1'b0;
        frame_length    <= 14'd0;
        ether_type      <= 16'd0;
        source_address  <= 32'd0;
        header_checksum <= 16'd0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_passthrough();
        test_translation();
        test_slot_removal();
        test_duplicate_keys();
        test_random_traffic();

        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Sent %0d table writes and %0d headers; %0d headers were translated.",
                 write_count, header_count, translate_count);
        $display("Covered removal, duplicate keys, short frames and foreign ethertypes.");
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
